[sv/sde_pkg.sv]
// ============================================================================
// sde_pkg: shared types and constants of the SHA-1 digest engine
// Holds the channel payload structs, the queue entry, and the fixed SHA-1
// constants used by the compression core.
// ============================================================================
package sde_pkg;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sde_in_t;

    // Output transaction payload.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } sde_out_t;

    // Work item passed from the front end to the core.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } sde_op_t;

    localparam logic [0:4][31:0] H_INIT = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

[sv/sde_front.sv]
// ============================================================================
// sde_front: input front end of the SHA-1 digest engine
// Accepts message transactions, drops those that carry neither a byte nor
// an end mark, and queues the rest for the compression core.
// ============================================================================
module sde_front #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  sde_pkg::sde_in_t  msg,
    output logic              q_valid,
    input  logic              q_ready,
    output sde_pkg::sde_op_t  q_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sde_pkg::sde_op_t fifo_mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             push;
    logic             pop;

    assign msg_ready = (cnt_reg != CW'(DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_op      = fifo_mem[rd_ptr_reg];

    // Only items that do something enter the queue.
    assign push = msg_valid && msg_ready && (msg.has_byte || msg.end_of_message);
    assign pop  = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{data: msg.data_byte, has_byte: msg.has_byte,
                                      last: msg.end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[sv/sde_core.sv]
// ============================================================================
// sde_core: SHA-1 block gathering, padding and compression
// Shifts bytes into a 512-bit block register, runs one round per cycle,
// pads the closing block and presents the digest through an output register.
// ============================================================================
module sde_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  sde_pkg::sde_op_t  q_op,
    output logic              digest_valid,
    input  logic              digest_ready,
    output sde_pkg::sde_out_t digest
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_FILL,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    state_t            state_reg;
    state_t            ret_reg;
    logic [5:0]        fill_reg;
    logic [63:0]       bitcnt_reg;
    logic [31:0]       chain_reg [5];
    logic [6:0]        rnd_reg;
    logic [2:0]        widx_reg;
    logic              out_valid_reg;
    sde_pkg::sde_out_t out_reg;

    logic [511:0]      blk_reg;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;

    logic              pop;
    logic              shift_en;
    logic [7:0]        shift_byte;
    logic              len_load;
    logic              work_load;
    logic              round_en;
    logic              out_load;

    logic [31:0]       w0, w2, w8, w13, w_mix, w_cur;
    logic [31:0]       f_val, k_val, round_sum;

    assign q_ready      = (state_reg == S_IDLE);
    assign pop          = q_valid && q_ready;
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || digest_ready);
    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    // Control strobes for the datapath.
    always_comb
    begin
        shift_en   = 1'b0;
        shift_byte = 8'h00;
        len_load   = 1'b0;
        round_en   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && q_op.has_byte)
                begin
                    shift_en   = 1'b1;
                    shift_byte = q_op.data;
                end
            end
            S_PAD:
            begin
                shift_en   = 1'b1;
                shift_byte = sde_pkg::PAD_BYTE;
            end
            S_FILL:
            begin
                if (fill_reg == sde_pkg::LEN_POS)
                begin
                    len_load = 1'b1;
                end
                else
                begin
                    shift_en = 1'b1;
                end
            end
            S_ROUND:
            begin
                round_en = 1'b1;
            end
            S_ADD, S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
        work_load = (shift_en && (fill_reg == sde_pkg::LAST_SLOT)) || len_load;
    end

    // Schedule taps: word j of the window sits at blk_reg[511-32j -: 32].
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_cur = (rnd_reg < 7'd16) ? w0 : {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        priority if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sde_pkg::K_R0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sde_pkg::K_R1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sde_pkg::K_R2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sde_pkg::K_R3;
        end
    end

    assign round_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // Block register and working variables.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            blk_reg <= {blk_reg[503:0], shift_byte};
        end
        else if (len_load)
        begin
            blk_reg <= {blk_reg[447:0], bitcnt_reg};
        end
        else if (round_en)
        begin
            blk_reg <= {blk_reg[479:0], w_cur};
        end

        if (work_load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (round_en)
        begin
            a_reg <= round_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            fill_reg      <= '0;
            bitcnt_reg    <= '0;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= sde_pkg::H_INIT[i];
            end
            rnd_reg       <= '0;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && digest_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (shift_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (len_load)
            begin
                fill_reg <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (q_op.has_byte)
                        begin
                            bitcnt_reg <= bitcnt_reg + 64'd8;
                            if (fill_reg == sde_pkg::LAST_SLOT)
                            begin
                                state_reg <= S_ROUND;
                                ret_reg   <= q_op.last ? S_PAD : S_IDLE;
                            end
                            else if (q_op.last)
                            begin
                                state_reg <= S_PAD;
                            end
                        end
                        else if (q_op.last)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (fill_reg == sde_pkg::LAST_SLOT)
                    begin
                        state_reg <= S_ROUND;
                        ret_reg   <= S_FILL;
                    end
                    else
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    if (fill_reg == sde_pkg::LEN_POS)
                    begin
                        state_reg <= S_ROUND;
                        ret_reg   <= S_OUT;
                    end
                    else if (fill_reg == sde_pkg::LAST_SLOT)
                    begin
                        state_reg <= S_ROUND;
                        ret_reg   <= S_FILL;
                    end
                end
                S_ROUND:
                begin
                    if (rnd_reg == sde_pkg::LAST_ROUND)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= S_ADD;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                end
                S_ADD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    widx_reg     <= '0;
                    state_reg    <= ret_reg;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg       <= '{digest_word: chain_reg[widx_reg],
                                           word_index:  widx_reg,
                                           digest_done: (widx_reg == sde_pkg::LAST_WORD)};
                        if (widx_reg == sde_pkg::LAST_WORD)
                        begin
                            // Message finished: back to the initial chaining value.
                            for (int i = 0; i < 5; i++)
                            begin
                                chain_reg[i] <= sde_pkg::H_INIT[i];
                            end
                            fill_reg   <= '0;
                            bitcnt_reg <= '0;
                            widx_reg   <= '0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            widx_reg <= widx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Every compression starts on a block boundary, so the fill count is zero.
    a_fill_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> (fill_reg == '0))
        else $error("fill count not zero after a block compression");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.digest_done == (out_reg.word_index == sde_pkg::LAST_WORD)))
        else $error("digest_done does not match the last word index");

    a_msg_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (widx_reg == sde_pkg::LAST_WORD)) |=>
        ((fill_reg == '0) && (bitcnt_reg == '0) && (state_reg == S_IDLE)))
        else $error("message state not cleared after the last digest word");

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ROUND) |-> (rnd_reg == '0))
        else $error("round counter left nonzero outside the round loop");

endmodule

[sv/sha1_digest_engine.sv]
// ============================================================================
// sha1_digest_engine: SHA-1 hash engine over a byte stream
// Top level joining the queueing front end and the compression core.
// ============================================================================
// Usage:
// The msg channel takes one transaction per message byte, first byte first.
// has_byte marks a real byte; end_of_message closes the message, and the
// closing transaction may carry no byte so that an empty message can be
// hashed. Transactions with neither flag are accepted and dropped.
// The digest channel returns five transactions per message, word 0 (most
// significant) first; digest_done is set on word 4.
// Throughput: a front queue takes one transaction per cycle while not full.
// The core drains one byte per cycle while idle and, on each full 64-byte
// block, runs 80 rounds in a single round unit, then the chaining add,
// before it takes the next byte.
// After the closing transaction the core pads, zero-fills one byte per cycle
// and runs one or two compressions, as the padding needs, before digest word 0;
// the words then follow one a cycle while digest_ready is high.
// Reset clears the queue and restores the initial chaining value.
// When digest_ready is low, the output register holds its word and the core
// waits; the queue keeps taking input transactions until it fills.
// ============================================================================
module sha1_digest_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  sde_pkg::sde_in_t  msg,
    output logic              digest_valid,
    input  logic              digest_ready,
    output sde_pkg::sde_out_t digest
);

    logic             q_valid;
    logic             q_ready;
    sde_pkg::sde_op_t q_op;

    // Front end: filters empty transactions and buffers the rest.
    sde_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_op      (q_op)
    );

    // Core: block gathering, padding, 80-round compression, digest output.
    sde_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_op         (q_op),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

[tb/sv/sha1_digest_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// sha1_digest_checker: digest predictor and scoreboard for the SHA-1 engine
// Watches both channels of the engine. Every accepted message transaction is
// fed to a software SHA-1 model that queues the five digest words a closing
// transaction produces; every accepted digest transaction is compared field by
// field with the oldest queued word.
// ============================================================================
module sha1_digest_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    input  logic              msg_ready,
    input  sde_pkg::sde_in_t  msg,
    input  logic              digest_valid,
    input  logic              digest_ready,
    input  sde_pkg::sde_out_t digest,
    output int                fail_count,
    output int                words_waiting,
    output int                words_checked
);

    localparam int REPORT_LIMIT  = 10;
    localparam int BLOCK_BYTES   = 64;
    localparam int LENGTH_OFFSET = 56;
    localparam int DIGEST_WORDS  = 5;

    // Model of the hash state.
    logic [31:0] chain_state [DIGEST_WORDS];
    logic [7:0]  block_buf [BLOCK_BYTES];
    int          fill_count;
    logic [63:0] bit_length;

    sde_pkg::sde_out_t expected_digest_words [$];

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void reset_hash_state();
        for (int j = 0; j < DIGEST_WORDS; j++)
            chain_state[j] = sde_pkg::H_INIT[j];
        fill_count = 0;
        bit_length = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, sum;
        int          slot;
        for (int j = 0; j < 16; j++)
        begin
            sched[j] = {block_buf[4 * j], block_buf[4 * j + 1],
                        block_buf[4 * j + 2], block_buf[4 * j + 3]};
        end
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        e = chain_state[4];
        for (int t = 0; t < 80; t++)
        begin
            slot = t & 15;
            // The schedule is kept as a rolling window of sixteen words.
            if (t >= 16)
            begin
                sched[slot] = rotl32(sched[(t + 13) & 15] ^ sched[(t + 8) & 15] ^
                                     sched[(t + 2) & 15] ^ sched[slot], 1);
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = sde_pkg::K_R0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = sde_pkg::K_R1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sde_pkg::K_R2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sde_pkg::K_R3;
            end
            sum = rotl32(a, 5) + f + e + k + sched[slot];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = sum;
        end
        chain_state[0] = chain_state[0] + a;
        chain_state[1] = chain_state[1] + b;
        chain_state[2] = chain_state[2] + c;
        chain_state[3] = chain_state[3] + d;
        chain_state[4] = chain_state[4] + e;
    endfunction

    function automatic void absorb_transaction(input sde_pkg::sde_in_t item);
        sde_pkg::sde_out_t word;
        if (item.has_byte)
        begin
            block_buf[fill_count] = item.data_byte;
            fill_count++;
            bit_length = bit_length + 64'd8;
            if (fill_count == BLOCK_BYTES)
            begin
                compress_block();
                fill_count = 0;
            end
        end
        if (!item.end_of_message)
            return;

        block_buf[fill_count] = sde_pkg::PAD_BYTE;
        fill_count++;
        // When the length no longer fits, close this block and pad a fresh one.
        if (fill_count > LENGTH_OFFSET)
        begin
            while (fill_count < BLOCK_BYTES)
            begin
                block_buf[fill_count] = 8'h00;
                fill_count++;
            end
            compress_block();
            fill_count = 0;
        end
        while (fill_count < LENGTH_OFFSET)
        begin
            block_buf[fill_count] = 8'h00;
            fill_count++;
        end
        for (int j = 0; j < 8; j++)
            block_buf[LENGTH_OFFSET + j] = bit_length[63 - 8 * j -: 8];
        compress_block();

        for (int j = 0; j < DIGEST_WORDS; j++)
        begin
            word.digest_word = chain_state[j];
            word.word_index  = 3'(j);
            word.digest_done = (j == DIGEST_WORDS - 1);
            expected_digest_words.push_back(word);
        end
        reset_hash_state();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sde_pkg::sde_out_t want;
        if (!rst_n)
        begin
            reset_hash_state();
            expected_digest_words.delete();
            fail_count    = 0;
            words_waiting = 0;
            words_checked = 0;
        end
        else
        begin
            if (msg_valid && msg_ready)
                absorb_transaction(msg);
            if (digest_valid && digest_ready)
            begin
                if (expected_digest_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected digest transaction: word %08h index %0d done %0b",
                                 digest.digest_word, digest.word_index, digest.digest_done);
                    end
                end
                else
                begin
                    want = expected_digest_words.pop_front();
                    words_checked++;
                    if (digest.digest_word !== want.digest_word ||
                        digest.word_index !== want.word_index ||
                        digest.digest_done !== want.digest_done)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                                     want.digest_word, want.word_index, want.digest_done,
                                     digest.digest_word, digest.word_index,
                                     digest.digest_done);
                        end
                    end
                end
            end
            words_waiting = expected_digest_words.size();
        end
    end

endmodule

[tb/sv/tb_sha1_digest_engine.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_sha1_digest_engine: self-checking testbench of the SHA-1 digest engine
// Drives message transactions into the engine and consumes its digest words,
// with a short directed sequence followed by randomly sized messages under
// four idle profiles. The checker beside the engine predicts and compares;
// this module makes the stimulus and gives the verdict.
// ============================================================================
module tb_sha1_digest_engine;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int NUM_PHASES      = 4;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NOISE_PCT       = 5;
    localparam int DRAIN_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic              clk;
    logic              rst_n;
    logic              msg_valid;
    logic              msg_ready;
    sde_pkg::sde_in_t  msg;
    logic              digest_valid;
    logic              digest_ready;
    sde_pkg::sde_out_t digest;

    int fail_count;
    int words_waiting;
    int words_checked;

    // Idle profiles, one per random phase: none, sender idle, receiver
    // stalling, and both at a moderate rate.
    int send_idle_profile [NUM_PHASES] = '{0, 82, 0, 34};
    int stall_profile     [NUM_PHASES] = '{0, 0, 82, 34};
    int send_idle_pct;
    int stall_pct;

    int messages_sent;
    int items_sent;
    int message_items;
    int longest_message;
    int idle_cycles;

    sha1_digest_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    sha1_digest_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg_valid     (msg_valid),
        .msg_ready     (msg_ready),
        .msg           (msg),
        .digest_valid  (digest_valid),
        .digest_ready  (digest_ready),
        .digest        (digest),
        .fail_count    (fail_count),
        .words_waiting (words_waiting),
        .words_checked (words_checked)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // The receiver decides afresh on every falling edge whether to stall.
    always @(negedge clk)
    begin
        if (!rst_n)
            digest_ready <= 1'b0;
        else
            digest_ready <= ($urandom_range(99) >= stall_pct);
    end

    // The watchdog counts cycles in which neither channel completes a
    // transaction. Any correct run stays far below the limit, even during the
    // deliberate pauses and the final drain.
    always @(posedge clk)
    begin
        if (!rst_n || (msg_valid && msg_ready) || (digest_valid && digest_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic sde_pkg::sde_in_t make_item(input logic [7:0] data, input logic has,
                                                   input logic last);
        sde_pkg::sde_in_t item;
        item.data_byte      = data;
        item.has_byte       = has;
        item.end_of_message = last;
        return item;
    endfunction

    // Called at a falling edge and returns at the falling edge after the
    // transaction was accepted. Valid stays high into the next call, so a
    // back-to-back transaction never sees valid drop.
    task automatic send_transaction(input sde_pkg::sde_in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= item;
        @(posedge clk);
        while (!msg_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Lower valid and hold off until every digest word has come back.
    task automatic wait_for_digests();
        msg_valid <= 1'b0;
        @(negedge clk);
        while (words_waiting != 0)
            @(negedge clk);
    endtask

    // One message of random bytes with transactions carrying neither flag
    // sprinkled in. The message closes either on its last byte or with an
    // extra transaction that carries no byte.
    task automatic send_message(input int len, input bit close_empty);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < NOISE_PCT)
                send_transaction(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
            send_transaction(make_item(8'($urandom_range(255)), 1'b1,
                                       !close_empty && (i == len - 1)));
            message_items++;
        end
        if (close_empty)
        begin
            send_transaction(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
            message_items++;
        end
        messages_sent++;
        if (len > longest_message)
            longest_message = len;
    endtask

    // Most messages are short; some sit on the padding boundaries, where the
    // length spills into an extra block or a block fills exactly; a few are
    // longer and span one or two blocks.
    function automatic int pick_length();
        int boundary [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(12);
        else if (r < 85)
            return boundary[$urandom_range(9)];
        else
            return $urandom_range(100, 13);
    endfunction

    initial
    begin
        int len;
        msg_valid       = 1'b0;
        msg             = '0;
        rst_n           = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        messages_sent   = 0;
        items_sent      = 0;
        message_items   = 0;
        longest_message = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An empty message closed by a transaction with no byte.
        send_transaction(make_item(8'h5A, 1'b0, 1'b1));
        // A single zero byte that also closes the message.
        send_transaction(make_item(8'h00, 1'b1, 1'b1));
        // A single all-ones byte followed by an empty closing transaction.
        send_transaction(make_item(8'hFF, 1'b1, 1'b0));
        send_transaction(make_item(8'hFF, 1'b0, 1'b1));
        // A transaction with neither flag must leave the state alone; then
        // the classic three-byte string.
        send_transaction(make_item(8'hA5, 1'b0, 1'b0));
        send_transaction(make_item(8'h61, 1'b1, 1'b0));
        send_transaction(make_item(8'h62, 1'b1, 1'b0));
        send_transaction(make_item(8'h63, 1'b1, 1'b1));
        // Ignored transaction in the middle of a message, with a full data byte.
        send_transaction(make_item(8'h80, 1'b1, 1'b0));
        send_transaction(make_item(8'h7F, 1'b1, 1'b0));
        send_transaction(make_item(8'hFF, 1'b0, 1'b0));
        send_transaction(make_item(8'h01, 1'b1, 1'b1));
        // Two empty messages back to back check that the chaining value is
        // restored after every digest.
        send_transaction(make_item(8'h00, 1'b0, 1'b1));
        send_transaction(make_item(8'hC3, 1'b0, 1'b1));
        messages_sent   = 7;
        longest_message = 3;
        wait_for_digests();

        // Random part, one idle profile per phase.
        message_items = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct = send_idle_profile[phase];
            stall_pct     = stall_profile[phase];
            while (message_items < (phase + 1) * ITEMS_PER_PHASE)
            begin
                len = pick_length();
                send_message(len, (len == 0) || ($urandom_range(3) == 0));
                // Now and then the sender waits for the engine to drain.
                if ($urandom_range(5) == 0)
                    wait_for_digests();
            end
            wait_for_digests();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Hashed %0d messages from %0d input transactions, longest %0d bytes.",
                 messages_sent, items_sent, longest_message);
        $display("Checked %0d digest words under four idle profiles, %0d mismatches.",
                 words_checked, fail_count);
        if (fail_count == 0 && words_waiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
